>>> design/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared constants, register codes and beat types for the 3x3 line-buffered
// correlation block.
// ----------------------------------------------------------------------------
`default_nettype none

package conv3_pkg;

  // defaults for the top-level parameters
  localparam int MAX_LINE_WIDTH_DEF = 1024;
  localparam int COEFF_BITS_DEF     = 16;

  // fixed geometry and field widths
  localparam int KERNEL_SIZE       = 3;
  localparam int KERNEL_TAPS       = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PIXEL_BITS        = 8;
  localparam int OUT_BITS          = 28;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 13;
  localparam int ROW_BITS          = 12;
  localparam int COEFF_REG_BITS    = 64;
  localparam int COEFF_LAST_BITS   = 16;
  localparam int TAPS_PER_REG      = 4;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int MIN_FRAME_DIM     = 3;
  localparam int MAX_FRAME_HEIGHT  = 4096;

  // reset values of the configuration registers
  localparam int FRAME_WIDTH_RST   = 1024;
  localparam int FRAME_HEIGHT_RST  = 480;

  // flow control: registered stages ahead of the result queue, and its depth
  localparam int PIPE_STAGES = 4;
  localparam int FIFO_DEPTH  = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEFFS_A     = 3'd2,
    REG_COEFFS_B     = 3'd3,
    REG_COEFF_LAST   = 3'd4
  } cfg_reg_t;

  // per-pixel control that rides along the pipeline
  typedef struct packed {
    logic emit;   // this pixel produces a result
    logic last;   // this pixel closes the frame
  } item_tag_t;

  // one result beat
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       last;
  } result_t;

endpackage

`default_nettype wire

>>> design/conv3_line_window.sv
// ----------------------------------------------------------------------------
// conv3_line_window
// Raster counters, the two line stores and the 3x3 pixel window.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_line_window #(
  parameter int MAX_LINE_WIDTH = conv3_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire logic [conv3_pkg::PIXEL_BITS-1:0]      pixel,
  input  wire logic [conv3_pkg::FRAME_WIDTH_BITS-1:0]  frame_width,
  input  wire logic [conv3_pkg::FRAME_HEIGHT_BITS-1:0] frame_height,
  output logic [conv3_pkg::KERNEL_TAPS-1:0][conv3_pkg::PIXEL_BITS-1:0] window,
  output conv3_pkg::item_tag_t                       window_tag
);
  import conv3_pkg::*;

  localparam int AW   = $clog2(MAX_LINE_WIDTH);
  localparam int CMPW = (AW + 1 > FRAME_WIDTH_BITS) ? AW + 1 : FRAME_WIDTH_BITS;

  logic [AW-1:0]                column_count;
  logic [ROW_BITS-1:0]          row_count;
  logic [CMPW-1:0]              width_eff;
  logic [CMPW-1:0]              width_last;
  logic [FRAME_HEIGHT_BITS-1:0] height_eff;
  logic [FRAME_HEIGHT_BITS-1:0] height_last;
  logic                         row_end;
  logic                         frame_end;
  logic                         emit;

  logic [PIXEL_BITS-1:0] older_mem [MAX_LINE_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_LINE_WIDTH];
  logic [PIXEL_BITS-1:0] top_rd;
  logic [PIXEL_BITS-1:0] mid_rd;
  logic [PIXEL_BITS-1:0] px_q;
  logic [AW-1:0]         col_q;
  logic                  s1_valid;
  item_tag_t             s1_tag;

  // clamp frame size
  always_comb begin
    if (CMPW'(frame_width) < CMPW'(MIN_FRAME_DIM)) begin
      width_eff = CMPW'(MIN_FRAME_DIM);
    end else if (CMPW'(frame_width) > CMPW'(MAX_LINE_WIDTH)) begin
      width_eff = CMPW'(MAX_LINE_WIDTH);
    end else begin
      width_eff = CMPW'(frame_width);
    end
    if (frame_height < FRAME_HEIGHT_BITS'(MIN_FRAME_DIM)) begin
      height_eff = FRAME_HEIGHT_BITS'(MIN_FRAME_DIM);
    end else if (frame_height > FRAME_HEIGHT_BITS'(MAX_FRAME_HEIGHT)) begin
      height_eff = FRAME_HEIGHT_BITS'(MAX_FRAME_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
    width_last  = width_eff - CMPW'(1);
    height_last = height_eff - FRAME_HEIGHT_BITS'(1);
    row_end     = CMPW'(column_count) >= width_last;
    frame_end   = row_end && (FRAME_HEIGHT_BITS'(row_count) >= height_last);
    emit        = (row_count >= ROW_BITS'(KERNEL_SIZE - 1)) &&
                  (column_count >= AW'(KERNEL_SIZE - 1));
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  // line stores: newer is read and rewritten on accept, older in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd                  <= older_mem[column_count];
      mid_rd                  <= newer_mem[column_count];
      newer_mem[column_count] <= pixel;
      px_q                    <= pixel;
      col_q                   <= column_count;
    end
    if (s1_valid) begin
      older_mem[col_q] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_tag   <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_tag.emit <= emit;
        s1_tag.last <= frame_end;
      end
    end
  end

  // window: shift one column left, new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      window_tag <= '0;
    end else begin
      window_tag.emit <= s1_valid && s1_tag.emit;
      window_tag.last <= s1_tag.last;
      if (s1_valid) begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
          for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
            window[r*KERNEL_SIZE + c] <= window[r*KERNEL_SIZE + c + 1];
          end
        end
        window[KERNEL_SIZE - 1]             <= top_rd;
        window[2*KERNEL_SIZE - 1]           <= mid_rd;
        window[KERNEL_SIZE*KERNEL_SIZE - 1] <= px_q;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac
// Nine parallel pixel-by-tap products, three partial sums, final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_mac #(
  parameter int COEFF_BITS = conv3_pkg::COEFF_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [conv3_pkg::KERNEL_TAPS-1:0][conv3_pkg::PIXEL_BITS-1:0] window,
  input  wire conv3_pkg::item_tag_t                   window_tag,
  input  wire logic [conv3_pkg::COEFF_REG_BITS-1:0]   coeffs_a,
  input  wire logic [conv3_pkg::COEFF_REG_BITS-1:0]   coeffs_b,
  input  wire logic signed [conv3_pkg::COEFF_LAST_BITS-1:0] coeff_last,
  output logic                                        res_valid,
  output conv3_pkg::result_t                          res
);
  import conv3_pkg::*;

  localparam int TW   = (COEFF_BITS > COEFF_LAST_BITS) ? COEFF_BITS : COEFF_LAST_BITS;
  localparam int PW   = TW + PIXEL_BITS + 1;
  localparam int SW   = PW + 4;
  localparam int ACCW = (SW > OUT_BITS) ? SW : OUT_BITS;

  logic signed [TW-1:0]   taps [KERNEL_TAPS];
  logic signed [PW-1:0]   prod [KERNEL_TAPS];
  logic signed [ACCW-1:0] part [KERNEL_SIZE];
  logic signed [ACCW-1:0] total;
  item_tag_t              tag_p;
  item_tag_t              tag_s;

  // unpack taps; a slot past the top of its register reads as zero
  for (genvar g = 0; g < 2; g++) begin : g_reg
    for (genvar s = 0; s < TAPS_PER_REG; s++) begin : g_slot
      logic [COEFF_REG_BITS-1:0] shifted;
      assign shifted = (g == 0 ? coeffs_a : coeffs_b) >> (s * COEFF_BITS);
      assign taps[g*TAPS_PER_REG + s] = TW'($signed(shifted[COEFF_BITS-1:0]));
    end
  end
  assign taps[KERNEL_TAPS-1] = TW'(coeff_last);

  always_ff @(posedge clk) begin
    for (int k = 0; k < KERNEL_TAPS; k++) begin
      prod[k] <= PW'($signed({1'b0, window[k]})) * PW'(taps[k]);
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      part[i] <= ACCW'(prod[i*KERNEL_SIZE]) + ACCW'(prod[i*KERNEL_SIZE + 1]) +
                 ACCW'(prod[i*KERNEL_SIZE + 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p <= '0;
      tag_s <= '0;
    end else begin
      tag_p <= window_tag;
      tag_s <= tag_p;
    end
  end

  assign total     = part[0] + part[1] + part[2];
  assign res_valid = tag_s.emit;
  assign res.value = total[OUT_BITS-1:0];
  assign res.last  = tag_s.last;

endmodule

`default_nettype wire

>>> design/conv3_out_fifo.sv
// ----------------------------------------------------------------------------
// conv3_out_fifo
// Small result queue between the free-running pipeline and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire conv3_pkg::result_t  wr_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output conv3_pkg::result_t       rd_data,
  output logic [$clog2(conv3_pkg::FIFO_DEPTH+1)-1:0] count
);
  import conv3_pkg::*;

  localparam int PTRW = $clog2(FIFO_DEPTH);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  result_t         slots [FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic            pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      count <= count + CNTW'(wr_en) - CNTW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> design/conv3x3_line_buffered.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffered
// Streaming 3x3 correlation over 8-bit grayscale frames, stride 1, no padding.
// ----------------------------------------------------------------------------
//
// Pixels enter in raster order, one beat per clock while in_stall is low. Two
// line stores of MAX_LINE_WIDTH bytes (one block RAM port set per row) and a
// 3x3 window feed nine parallel 8-bit by COEFF_BITS multipliers, so the block
// sustains one pixel per clock with no gaps while the output is not stalled.
// From the third row on, every pixel from the third column on yields one
// result: the unflipped sum of the nine products, tap 0 at top left, tap 8
// the pixel just taken, exact in signed Q.8 (28 bits, no saturation).
// frame_last marks the result of the pixel closing the frame. From input beat
// to result the registered steps are line store read, window shift, products,
// three partial sums, then the final add into an 8-deep result queue. The
// pipeline never stalls internally; in_stall rises when the queue holds more
// than 3 results, so a stalled output throttles the input. Width is clamped
// to 3..MAX_LINE_WIDTH and height to 3..4096. The line stores are not cleared
// at reset; they need no clearing pass since every entry that feeds a result
// within a frame of stable width was written by the previous rows.
// Configuration is written through cfg_write_en/cfg_index/cfg_data; the user
// must do so only while the block is idle; the block does not enforce this.
`default_nettype none

module conv3x3_line_buffered #(
  parameter int MAX_LINE_WIDTH = conv3_pkg::MAX_LINE_WIDTH_DEF,
  parameter int COEFF_BITS     = conv3_pkg::COEFF_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration
  input  wire logic                                  cfg_write_en,
  input  wire logic [conv3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [conv3_pkg::COEFF_REG_BITS-1:0]  cfg_data,
  // pixel input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [conv3_pkg::PIXEL_BITS-1:0]      pixel,
  // result output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [conv3_pkg::OUT_BITS-1:0]      filtered_value,
  output logic                                       frame_last
);
  import conv3_pkg::*;

  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  logic [FRAME_WIDTH_BITS-1:0]     frame_width;
  logic [FRAME_HEIGHT_BITS-1:0]    frame_height;
  logic [COEFF_REG_BITS-1:0]       coeffs_a;
  logic [COEFF_REG_BITS-1:0]       coeffs_b;
  logic signed [COEFF_LAST_BITS-1:0] coeff_last;

  logic                                     accept;
  logic [KERNEL_TAPS-1:0][PIXEL_BITS-1:0]   window;
  item_tag_t                                window_tag;
  logic                                     res_valid;
  result_t                                  res;
  result_t                                  head;
  logic [CNTW-1:0]                          fifo_count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_BITS'(FRAME_WIDTH_RST);
      frame_height <= FRAME_HEIGHT_BITS'(FRAME_HEIGHT_RST);
      coeffs_a     <= '0;
      coeffs_b     <= '0;
      coeff_last   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_BITS-1:0];
        REG_COEFFS_A:     coeffs_a     <= cfg_data;
        REG_COEFFS_B:     coeffs_b     <= cfg_data;
        REG_COEFF_LAST:   coeff_last   <= $signed(cfg_data[COEFF_LAST_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Take a beat only if the queue can absorb it plus everything in flight.
  assign in_stall = fifo_count > CNTW'(FIFO_DEPTH - PIPE_STAGES - 1);
  assign accept   = in_valid && !in_stall;

  conv3_line_window #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .window       (window),
    .window_tag   (window_tag)
  );

  conv3_mac #(
    .COEFF_BITS (COEFF_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .window_tag (window_tag),
    .coeffs_a   (coeffs_a),
    .coeffs_b   (coeffs_b),
    .coeff_last (coeff_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  conv3_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_valid),
    .wr_data   (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rd_data   (head),
    .count     (fifo_count)
  );

  assign filtered_value = head.value;
  assign frame_last     = head.last;

  // queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNTW'(FIFO_DEPTH))
    else $error("result queue over depth");

  // no result lands in a full queue unless one leaves in the same cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && fifo_count == CNTW'(FIFO_DEPTH) && !(out_valid && !out_stall)))
    else $error("result written into full queue");

  // output comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

>>> test/conv3x3_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_result_check
// Passive checker for the 3x3 line-buffered correlation. It follows register
// writes and pixel beats, keeps its own line stores and window, predicts every
// result beat and compares each arriving beat with the oldest prediction.
// ----------------------------------------------------------------------------
module conv3x3_result_check (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [conv3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [conv3_pkg::COEFF_REG_BITS-1:0]  cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [conv3_pkg::PIXEL_BITS-1:0]      pixel,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [conv3_pkg::OUT_BITS-1:0] filtered_value,
  input  logic                                  frame_last,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    checked_count
);
  import conv3_pkg::*;

  localparam int MAX_LINE     = MAX_LINE_WIDTH_DEF;
  localparam int TAP_BITS     = COEFF_BITS_DEF;
  localparam int REPORT_LIMIT = 100;  // keep a broken run readable

  logic [PIXEL_BITS-1:0]        older_row [MAX_LINE];
  logic [PIXEL_BITS-1:0]        newer_row [MAX_LINE];
  logic [PIXEL_BITS-1:0]        win [KERNEL_TAPS];
  logic [$clog2(MAX_LINE)-1:0]  col_cnt;
  logic [ROW_BITS-1:0]          row_cnt;
  logic [FRAME_WIDTH_BITS-1:0]  width_reg;
  logic [FRAME_HEIGHT_BITS-1:0] height_reg;
  logic [COEFF_REG_BITS-1:0]    taps_lo;
  logic [COEFF_REG_BITS-1:0]    taps_hi;
  logic [COEFF_LAST_BITS-1:0]   tap_last;

  result_t expected_sums [$];
  int      errs = 0;
  int      n_checked = 0;

  task automatic clear_state();
    for (int i = 0; i < MAX_LINE; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int k = 0; k < KERNEL_TAPS; k++) win[k] = '0;
    col_cnt    = '0;
    row_cnt    = '0;
    width_reg  = FRAME_WIDTH_BITS'(FRAME_WIDTH_RST);
    height_reg = FRAME_HEIGHT_BITS'(FRAME_HEIGHT_RST);
    taps_lo    = '0;
    taps_hi    = '0;
    tap_last   = '0;
    expected_sums.delete();
  endtask

  // tap 0 is top left, taps 0..3 in the low word, 4..7 in the high word
  function automatic logic signed [TAP_BITS-1:0] tap_weight(input int k);
    if (k < TAPS_PER_REG) return taps_lo[TAP_BITS*k +: TAP_BITS];
    if (k < 2 * TAPS_PER_REG) return taps_hi[TAP_BITS*(k-TAPS_PER_REG) +: TAP_BITS];
    return tap_last;
  endfunction

  task automatic advance_window(input logic [PIXEL_BITS-1:0] px);
    int                    w;
    int                    h;
    logic [PIXEL_BITS-1:0] top_px;
    logic [PIXEL_BITS-1:0] mid_px;
    logic                  emit;
    logic                  row_end;
    logic                  frame_end;
    longint                acc;
    result_t               res;
    w = (int'(width_reg) < MIN_FRAME_DIM) ? MIN_FRAME_DIM :
        (int'(width_reg) > MAX_LINE) ? MAX_LINE : int'(width_reg);
    h = (int'(height_reg) < MIN_FRAME_DIM) ? MIN_FRAME_DIM :
        (int'(height_reg) > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : int'(height_reg);
    top_px = older_row[col_cnt];
    mid_px = newer_row[col_cnt];
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win[r*KERNEL_SIZE + c] = win[r*KERNEL_SIZE + c + 1];
      end
    end
    win[KERNEL_SIZE-1]     = top_px;
    win[2*KERNEL_SIZE-1]   = mid_px;
    win[KERNEL_TAPS-1]     = px;
    older_row[col_cnt]     = mid_px;
    newer_row[col_cnt]     = px;

    emit      = (row_cnt >= 2) && (col_cnt >= 2);
    row_end   = int'(col_cnt) >= w - 1;
    frame_end = row_end && (int'(row_cnt) >= h - 1);

    if (emit) begin
      acc = 0;
      for (int k = 0; k < KERNEL_TAPS; k++) begin
        acc += longint'(win[k]) * longint'(tap_weight(k));
      end
      res.value = acc[OUT_BITS-1:0];
      res.last  = frame_end;
      expected_sums.insert(expected_sums.size(), res);
    end

    if (row_end) begin
      col_cnt = '0;
      if (frame_end) row_cnt = '0;
      else row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  task automatic compare_result();
    result_t want;
    n_checked++;
    if (expected_sums.size() == 0) begin
      errs++;
      if (errs <= REPORT_LIMIT)
        $error("filtered_value: expected no beat, got %0d (frame_last %0b)",
               filtered_value, frame_last);
    end else begin
      want = expected_sums.pop_front();
      if (filtered_value !== want.value) begin
        errs++;
        if (errs <= REPORT_LIMIT)
          $error("filtered_value: expected %0d, got %0d", want.value, filtered_value);
      end
      if (frame_last !== want.last) begin
        errs++;
        if (errs <= REPORT_LIMIT)
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
      end
    end
  endtask

  // results never leave on the edge that takes their pixel, so results are
  // matched before the pixel of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_data[FRAME_WIDTH_BITS-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[FRAME_HEIGHT_BITS-1:0];
          REG_COEFFS_A:     taps_lo    = cfg_data;
          REG_COEFFS_B:     taps_hi    = cfg_data;
          REG_COEFF_LAST:   tap_last   = cfg_data[COEFF_LAST_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall) advance_window(pixel);
    end
    fail_count    <= errs;
    pending       <= expected_sums.size();
    checked_count <= n_checked;
  end

endmodule

>>> test/conv3x3_line_buffered_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_line_buffered_test
// Drives raster-order frames into the 3x3 correlation block under random
// sender bursts and receiver stalls; a separate checker predicts and compares
// every result beat, and this top reports the verdict.
// ----------------------------------------------------------------------------
module conv3x3_line_buffered_test;
  import conv3_pkg::*;

  localparam int RANDOM_PIXELS = 360;  // random part stops after this many beats
  localparam int BURST_MAX     = 16;
  localparam int GAP_MAX       = 5;
  localparam int FILL_RANDOM   = -1;   // send_frame: random pixels, else a constant
  // pipeline registers plus an 8-entry result queue; settle well past that
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [COEFF_REG_BITS-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [PIXEL_BITS-1:0]     pixel = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OUT_BITS-1:0] filtered_value;
  logic                      frame_last;

  int fail_count;
  int pending;
  int checked_count;

  // stimulus bookkeeping
  int eff_w;
  int eff_h;
  int gap_max = 0;
  int burst_left = 0;
  int frames_sent = 0;
  int pixels_sent = 0;
  int programs = 0;

  always #5 clk = ~clk;

  conv3x3_line_buffered dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .frame_last     (frame_last)
  );

  conv3x3_result_check u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .frame_last     (frame_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked_count  (checked_count)
  );

  // One register write per clock; write enable stays high across a group
  // and is dropped once by the caller.
  task automatic write_reg(input cfg_reg_t idx, input logic [COEFF_REG_BITS-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
  endtask

  // Program all five registers. Unused upper data bits carry junk so the
  // block's masking of narrow registers gets exercised too.
  task automatic program_frame(input logic [FRAME_WIDTH_BITS-1:0] w_reg,
                               input logic [FRAME_HEIGHT_BITS-1:0] h_reg,
                               input logic [COEFF_REG_BITS-1:0] lo,
                               input logic [COEFF_REG_BITS-1:0] hi,
                               input logic [COEFF_LAST_BITS-1:0] last);
    logic [COEFF_REG_BITS-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_FRAME_WIDTH, {junk[COEFF_REG_BITS-1:FRAME_WIDTH_BITS], w_reg});
    write_reg(REG_FRAME_HEIGHT, {junk[COEFF_REG_BITS-1:FRAME_HEIGHT_BITS], h_reg});
    write_reg(REG_COEFFS_A, lo);
    write_reg(REG_COEFFS_B, hi);
    write_reg(REG_COEFF_LAST, {junk[COEFF_REG_BITS-1:COEFF_LAST_BITS], last});
    cfg_write_en <= 1'b0;
    @(posedge clk);
    // frame geometry as the block clamps it
    eff_w = (int'(w_reg) < MIN_FRAME_DIM) ? MIN_FRAME_DIM :
            (int'(w_reg) > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : int'(w_reg);
    eff_h = (int'(h_reg) < MIN_FRAME_DIM) ? MIN_FRAME_DIM :
            (int'(h_reg) > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : int'(h_reg);
    programs++;
  endtask

  // One pixel beat. A new burst starts with a random gap; valid is only
  // lowered when the gap is non-empty, so it never drops and rises in the
  // same step. The payload holds while the block stalls.
  task automatic push_pixel(input logic [PIXEL_BITS-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, BURST_MAX);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // A whole frame at the current geometry, so every register change lands
  // on a frame boundary and the line stores are always refilled first.
  task automatic send_frame(input int fill);
    logic [PIXEL_BITS-1:0] px;
    for (int i = 0; i < eff_w * eff_h; i++) begin
      if (fill != FILL_RANDOM) begin
        px = fill[PIXEL_BITS-1:0];
      end else begin
        case ($urandom_range(0, 9))
          0: px = '0;
          1: px = '1;
          default: px = PIXEL_BITS'($urandom);
        endcase
      end
      push_pixel(px);
    end
    frames_sent++;
  endtask

  // Sender pause: hold off until every predicted result has arrived, then
  // let the pipeline settle before anything is reprogrammed.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall pattern changes at random intervals, including stretches
  // with no stall at all and long stalls that back up the queue.
  initial begin
    stall_mode_t mode;
    @(posedge clk);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(10, 60)) begin
        case (mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
            @(posedge clk);
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
          end
          STALL_HEAVY: begin
            out_stall <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
          default: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // Main stimulus
  initial begin
    int                         base;
    logic [FRAME_WIDTH_BITS-1:0]  w_reg;
    logic [FRAME_HEIGHT_BITS-1:0] h_reg;
    logic [COEFF_REG_BITS-1:0]    lo;
    logic [COEFF_REG_BITS-1:0]    hi;
    logic [COEFF_LAST_BITS-1:0]   last;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // all-zero size registers clamp to 3x3; full-scale pixels against the
    // largest positive taps give the top of the output range
    program_frame('0, '0, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
    send_frame(8'hFF);
    wait_idle();
    // most negative taps give the bottom of the range
    program_frame(11'd3, 13'd3, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    send_frame(8'hFF);
    wait_idle();
    // distinct taps per position catch window or tap ordering mix-ups;
    // height 2 clamps up to 3, tap 8 is -1.0
    program_frame(11'd3, 13'd2, 64'h0400_0300_0200_0100, 64'h0800_0700_0600_0500,
                  16'hFF00);
    gap_max = 2;
    send_frame(FILL_RANDOM);
    wait_idle();

    // --- random small frames ---
    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      if ($urandom_range(0, 4) == 0) w_reg = FRAME_WIDTH_BITS'($urandom_range(11, 24));
      else w_reg = FRAME_WIDTH_BITS'($urandom_range(3, 10));
      h_reg = FRAME_HEIGHT_BITS'($urandom_range(3, 7));
      case ($urandom_range(0, 5))
        0: begin
          lo = {4{16'h7FFF}}; hi = lo; last = 16'h7FFF;
        end
        1: begin
          lo = {4{16'h8000}}; hi = lo; last = 16'h8000;
        end
        default: begin
          lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
          last = COEFF_LAST_BITS'($urandom);
        end
      endcase
      program_frame(w_reg, h_reg, lo, hi, last);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = GAP_MAX;
      endcase
      repeat ($urandom_range(1, 2)) send_frame(FILL_RANDOM);
      wait_idle();
    end

    $display("Summary: %0d pixel beats in %0d frames, %0d result beats compared",
             pixels_sent, frames_sent, checked_count);
    $display("Summary: %0d register settings, frames 3 to 24 wide and 3 to 7 tall, %s",
             programs, "low size clamps included");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
